/* hdl/kat_pkg.sv */
// Shared types and constants of the keyed aging table.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package kat_pkg;

	localparam int KEY_W  = 32;
	localparam int KIND_W = 8;
	localparam int PAY_W  = 64;
	localparam int AGE_W  = 8;
	localparam int REQ_W  = 2;
	localparam int SLOT_W = 5;
	localparam int CNT_W  = 6;

	localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

	localparam logic [AGE_W-1:0] MAX_AGE_RST = 8'd25;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [KIND_W-1:0] kind;
		logic [PAY_W-1:0]  payload;
		logic [AGE_W-1:0]  age;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;  // capture a new request and restart the scan
		logic run;   // a scan is in progress
		logic adv;   // the scan may advance this cycle
	} kat_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic finish;  // the current request has its result this cycle
	} kat_sts_t;

endpackage

`default_nettype wire

/* hdl/kat_req_if.sv */
// Request channel of the keyed aging table: valid/ready plus the request fields.
// Depends on kat_pkg for the field widths.
`default_nettype none

interface kat_req_if import kat_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [KEY_W-1:0]  entity_id;
	logic [KIND_W-1:0] entry_kind;
	logic [PAY_W-1:0]  payload;

	modport source (output valid, req_type, entity_id, entry_kind, payload, input ready);
	modport sink (input valid, req_type, entity_id, entry_kind, payload, output ready);
endinterface

`default_nettype wire

/* hdl/kat_rsp_if.sv */
// Result channel of the keyed aging table: valid/ready plus the result fields.
// Depends on kat_pkg for the field widths.
`default_nettype none

interface kat_rsp_if import kat_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              hit;
	logic [SLOT_W-1:0] slot;
	logic              table_full;
	logic [CNT_W-1:0]  entry_count;
	logic [CNT_W-1:0]  removed_count;

	modport source (output valid, hit, slot, table_full, entry_count, removed_count,
		input ready);
	modport sink (input valid, hit, slot, table_full, entry_count, removed_count,
		output ready);
endinterface

`default_nettype wire

/* hdl/kat_ctrl.sv */
// Controller of the keyed aging table: request handshake, scan sequencing, result valid.
// Depends on kat_pkg for the command and status structs.
`default_nettype none

module kat_ctrl import kat_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output kat_cmd_t      cmd,
	input  wire kat_sts_t sts
);

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   hold;
	logic   done;

	// A finished result must wait while the previous one is still unclaimed.
	assign hold      = sts.finish && out_valid_q && !out_ready;
	assign done      = sts.finish && !hold;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.run  = (state_q == ST_SCAN);
		cmd.adv  = (state_q == ST_SCAN) && !hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/kat_datapath.sv */
// Datapath of the keyed aging table: entry memory, scan and compaction counters,
// max_age register and result registers. Depends on kat_pkg.
`default_nettype none

module kat_datapath import kat_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [AGE_W-1:0]  cfg_wdata,
	input  wire logic [REQ_W-1:0]  req_type,
	input  wire logic [KEY_W-1:0]  entity_id,
	input  wire logic [KIND_W-1:0] entry_kind,
	input  wire logic [PAY_W-1:0]  payload,
	input  wire kat_cmd_t          cmd,
	output kat_sts_t               sts,
	output logic                   hit,
	output logic [SLOT_W-1:0]      slot,
	output logic                   table_full,
	output logic [CNT_W-1:0]       entry_count,
	output logic [CNT_W-1:0]       removed_count
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	entry_t mem [TABLE_DEPTH];

	logic [REQ_W-1:0]  req_q;
	logic [KEY_W-1:0]  ent_q;
	logic [KIND_W-1:0] kind_q;
	logic [PAY_W-1:0]  pay_q;
	logic [AGE_W-1:0]  max_age_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     rd_idx_q;
	logic [CW-1:0]     kept_q;
	logic [CW-1:0]     removed_q;
	logic              pend_s1;
	logic [AW-1:0]     idx_s1;
	entry_t            rdata_s1;

	logic              hit_q;
	logic [SLOT_W-1:0] slot_q;
	logic              full_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  removed_out_q;

	logic          issue;
	logic          key_eq;
	logic          hit_now;
	logic          finish;
	logic          commit;
	logic          aged;
	logic          room;
	logic          is_update;
	logic          is_tick;
	logic          insert;
	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;

	assign is_update = (req_q == REQ_UPDATE);
	assign is_tick   = (req_q == REQ_TICK);
	assign issue     = (rd_idx_q < fill_q);
	assign key_eq    = (rdata_s1.key == ent_q);
	assign hit_now   = pend_s1 && ((is_update && key_eq && (rdata_s1.kind == kind_q)) ||
		((req_q == REQ_LOOKUP) && key_eq));
	assign finish    = cmd.run && (hit_now || (!pend_s1 && !issue));
	assign commit    = finish && cmd.adv;
	assign aged      = (rdata_s1.age >= max_age_q);
	assign room      = (fill_q < DEPTH_C);
	assign insert    = is_update && !hit_now && room;
	assign sts.finish = finish;

	// One write port: survivors of a tick are packed down to the kept index,
	// an update hit rewrites in place, and an insert appends at the fill count.
	always_comb begin
		we    = 1'b0;
		waddr = kept_q[AW-1:0];
		wdata = rdata_s1;
		wdata.age = rdata_s1.age + AGE_W'(1);
		if (cmd.adv && pend_s1 && is_tick && !aged) begin
			we = 1'b1;
		end
		if (commit && is_update && hit_now) begin
			we    = 1'b1;
			waddr = idx_s1;
			wdata = '{key: ent_q, kind: kind_q, payload: pay_q, age: '0};
		end else if (commit && insert) begin
			we    = 1'b1;
			waddr = fill_q[AW-1:0];
			wdata = '{key: ent_q, kind: kind_q, payload: pay_q, age: '0};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.adv && issue) begin
			rdata_s1 <= mem[rd_idx_q[AW-1:0]];
			idx_s1   <= rd_idx_q[AW-1:0];
		end
		if (cmd.load) begin
			ent_q  <= entity_id;
			kind_q <= entry_kind;
			pay_q  <= payload;
		end
		if (commit) begin
			hit_q  <= hit_now;
			full_q <= is_update && !hit_now && !room;
			if (hit_now) begin
				slot_q <= SLOT_W'(idx_s1);
			end else if (insert) begin
				slot_q <= SLOT_W'(fill_q);
			end else begin
				slot_q <= '0;
			end
			if (is_tick) begin
				count_q       <= CNT_W'(kept_q);
				removed_out_q <= CNT_W'(removed_q);
			end else begin
				count_q       <= insert ? CNT_W'(fill_q + CW'(1)) : CNT_W'(fill_q);
				removed_out_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q     <= REQ_UPDATE;
			max_age_q <= MAX_AGE_RST;
			fill_q    <= '0;
			rd_idx_q  <= '0;
			kept_q    <= '0;
			removed_q <= '0;
			pend_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_age_q <= cfg_wdata;
			end
			if (cmd.load) begin
				req_q     <= req_type;
				rd_idx_q  <= '0;
				kept_q    <= '0;
				removed_q <= '0;
				pend_s1   <= 1'b0;
			end else if (cmd.adv) begin
				pend_s1 <= issue && !finish;
				if (issue) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (pend_s1 && is_tick) begin
					if (aged) begin
						removed_q <= removed_q + CW'(1);
					end else begin
						kept_q <= kept_q + CW'(1);
					end
				end
				if (commit) begin
					if (is_tick) begin
						fill_q <= kept_q;
					end else if (insert) begin
						fill_q <= fill_q + CW'(1);
					end
				end
			end
		end
	end

	assign hit           = hit_q;
	assign slot          = slot_q;
	assign table_full    = full_q;
	assign entry_count   = count_q;
	assign removed_count = removed_out_q;

endmodule

`default_nettype wire

/* hdl/keyed_aging_table_unit.sv */
// Top level of the keyed aging table: controller plus datapath behind two channels.
// Depends on kat_pkg, kat_req_if, kat_rsp_if, kat_ctrl and kat_datapath.
//
// Usage: requests enter on the req channel (update/insert, tick, lookup by entity)
// and exactly one result per request leaves on the rsp channel. Both channels
// move a transaction when valid and ready are high at a rising clock edge.
// The max_age register is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, the block itself does not enforce this. One request
// is worked on at a time. Each request scans the table one entry per cycle, unless
// a finished scan holds for rsp, through an entry memory with one write port and one
// registered read port. The result is registered once the scan has read every entry
// for a tick, an update miss, a lookup miss or an unknown request, and once it reads
// the hit entry for a hit; rsp can take it from the next edge on, where req can also
// take the next request. req.ready is high whenever no scan runs, so a new request
// can be taken while a previous result still waits on rsp.
// When rsp is stalled and the next scan finishes, the scan holds until the
// earlier result is taken. Reset empties the table (fill count zero, no clearing
// pass is needed) and sets max_age to 25.
`default_nettype none

module keyed_aging_table_unit import kat_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [AGE_W-1:0] cfg_wdata,
	kat_req_if.sink               req,
	kat_rsp_if.source             rsp
);

	kat_cmd_t cmd;
	kat_sts_t sts;

	kat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	kat_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req_type      (req.req_type),
		.entity_id     (req.entity_id),
		.entry_kind    (req.entry_kind),
		.payload       (req.payload),
		.cmd           (cmd),
		.sts           (sts),
		.hit           (rsp.hit),
		.slot          (rsp.slot),
		.table_full    (rsp.table_full),
		.entry_count   (rsp.entry_count),
		.removed_count (rsp.removed_count)
	);

endmodule

`default_nettype wire

/* dv/kat_table_check.sv */
// Checker for the keyed aging table: keeps its own copy of the table and of max_age,
// predicts one result per accepted request and compares it with the result channel.
// Depends on kat_pkg and the kat_req_if / kat_rsp_if interfaces.

module kat_table_check import kat_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [AGE_W-1:0] cfg_wdata,
	kat_req_if               req,
	kat_rsp_if               rsp,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              table_full;
		logic [CNT_W-1:0]  entry_count;
		logic [CNT_W-1:0]  removed_count;
	} table_result_t;

	logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
	logic [KIND_W-1:0] kind_mem [TABLE_DEPTH];
	logic [PAY_W-1:0]  pay_mem  [TABLE_DEPTH];
	logic [AGE_W-1:0]  age_mem  [TABLE_DEPTH];
	int unsigned       n_held;
	logic [AGE_W-1:0]  age_limit;
	table_result_t     result_q [$];
	int                errors = 0;

	assign fail_count = errors;

	// Applies one request to the shadow table and returns the result it must produce.
	function automatic table_result_t apply_request(logic [REQ_W-1:0] op,
		logic [KEY_W-1:0] ent, logic [KIND_W-1:0] knd, logic [PAY_W-1:0] pay);
		table_result_t res;
		bit found;
		int unsigned kept;
		int unsigned gone;
		res = '0;
		found = 1'b0;
		kept = 0;
		gone = 0;
		case (op)
			REQ_UPDATE: begin
				for (int i = 0; i < n_held; i++) begin
					if (!found && key_mem[i] == ent && kind_mem[i] == knd) begin
						pay_mem[i] = pay;
						age_mem[i] = '0;
						res.hit = 1'b1;
						res.slot = SLOT_W'(i);
						found = 1'b1;
					end
				end
				if (!found) begin
					if (n_held < TABLE_DEPTH) begin
						key_mem[n_held] = ent;
						kind_mem[n_held] = knd;
						pay_mem[n_held] = pay;
						age_mem[n_held] = '0;
						res.slot = SLOT_W'(n_held);
						n_held++;
					end else begin
						res.table_full = 1'b1;
					end
				end
			end
			REQ_TICK: begin
				// Survivors slide down over the removed entries in their original order.
				for (int i = 0; i < n_held; i++) begin
					if (age_mem[i] >= age_limit) begin
						gone++;
					end else begin
						key_mem[kept] = key_mem[i];
						kind_mem[kept] = kind_mem[i];
						pay_mem[kept] = pay_mem[i];
						age_mem[kept] = age_mem[i] + 1'b1;
						kept++;
					end
				end
				n_held = kept;
				res.removed_count = CNT_W'(gone);
			end
			REQ_LOOKUP: begin
				for (int i = 0; i < n_held; i++) begin
					if (!found && key_mem[i] == ent) begin
						res.hit = 1'b1;
						res.slot = SLOT_W'(i);
						found = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		res.entry_count = CNT_W'(n_held);
		return res;
	endfunction

	task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: result field %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			n_held = 0;
			age_limit = MAX_AGE_RST;
			result_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				age_limit = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result transaction, actual %b/%0d/%b/%0d/%0d",
						$time, rsp.hit, rsp.slot, rsp.table_full, rsp.entry_count,
						rsp.removed_count);
					errors++;
				end else begin
					want = result_q.pop_front();
					compare_field("hit", 8'(want.hit), 8'(rsp.hit));
					compare_field("slot", 8'(want.slot), 8'(rsp.slot));
					compare_field("table_full", 8'(want.table_full), 8'(rsp.table_full));
					compare_field("entry_count", 8'(want.entry_count), 8'(rsp.entry_count));
					compare_field("removed_count", 8'(want.removed_count),
						8'(rsp.removed_count));
				end
			end
			if (req.valid && req.ready)
				result_q = {result_q, apply_request(req.req_type, req.entity_id,
					req.entry_kind, req.payload)};
			pending <= result_q.size();
		end
	end

endmodule

/* dv/tb.sv */
// Testbench top for keyed_aging_table_unit: clock, reset, request and stall stimulus,
// max_age phases and the final verdict. Checking is done by kat_table_check.
// Depends on kat_pkg, kat_req_if, kat_rsp_if, kat_table_check and the block itself.

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kat_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
	localparam int DEPTH = 32;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [AGE_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;
	int unsigned      gap_pct;
	int unsigned      stall_pct;
	int unsigned      stall_left;
	int unsigned      quiet_cycles;
	int unsigned      sent_count;
	int unsigned      age_writes;

	kat_req_if req ();
	kat_rsp_if rsp ();

	keyed_aging_table_unit #(.TABLE_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	kat_table_check #(.TABLE_DEPTH(DEPTH)) table_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: random stall bursts whose frequency each phase sets.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left != 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp.ready <= 1'b1;
			if ($urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, 17);
		end
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Holds the request until it is taken, then maybe leaves a gap before the next one.
	task automatic send_item(logic [REQ_W-1:0] op, logic [KEY_W-1:0] ent,
		logic [KIND_W-1:0] knd, logic [PAY_W-1:0] pay);
		int unsigned gap;
		req.valid <= 1'b1;
		req.req_type <= op;
		req.entity_id <= ent;
		req.entry_kind <= knd;
		req.payload <= pay;
		do @(posedge clk); while (!req.ready);
		sent_count++;
		if ($urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 17);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_max_age(logic [AGE_W-1:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		age_writes++;
	endtask

	task automatic run_phase(int unsigned n_items, logic [AGE_W-1:0] age,
		int unsigned pool, int unsigned tick_pct, int unsigned idle_pct);
		logic [KEY_W-1:0]  ids   [32];
		logic [KIND_W-1:0] kinds [64];
		int unsigned r;
		int unsigned j;
		write_max_age(age);
		gap_pct = idle_pct;
		stall_pct = idle_pct;
		// Pool slots share entities in pairs, so an entity usually exists under two kinds.
		foreach (ids[k])
			ids[k] = $urandom();
		foreach (kinds[k])
			kinds[k] = KIND_W'($urandom_range(0, 255));
		send_item(REQ_TICK, $urandom(), KIND_W'($urandom_range(0, 255)),
			{$urandom(), $urandom()});
		repeat (n_items) begin
			r = $urandom_range(0, 99);
			j = $urandom_range(0, pool - 1);
			if (r < 4)
				send_item(REQ_W'($urandom_range(0, 3)), $urandom(),
					KIND_W'($urandom_range(0, 255)), {$urandom(), $urandom()});
			else if (r < 4 + tick_pct)
				send_item(REQ_TICK, $urandom(), KIND_W'($urandom_range(0, 255)),
					{$urandom(), $urandom()});
			else if (r < 24 + tick_pct)
				send_item(REQ_LOOKUP, ($urandom_range(0, 9) == 0) ? $urandom() : ids[j / 2],
					KIND_W'($urandom_range(0, 255)), {$urandom(), $urandom()});
			else
				send_item(REQ_UPDATE, ids[j / 2], kinds[j], {$urandom(), $urandom()});
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.req_type = REQ_UPDATE;
		req.entity_id = '0;
		req.entry_kind = '0;
		req.payload = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		sent_count = 0;
		age_writes = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset value of max_age.
		send_item(REQ_LOOKUP, '0, '0, '0);
		send_item(REQ_TICK, '0, '0, '0);
		send_item(REQ_UNKNOWN, '1, '1, '1);
		send_item(REQ_UPDATE, '0, '0, '0);
		send_item(REQ_UPDATE, '1, '1, '1);
		send_item(REQ_UPDATE, '0, '0, 64'h0123_4567_89ab_cdef);
		send_item(REQ_UPDATE, '0, 8'd1, 64'hfedc_ba98_7654_3210);
		send_item(REQ_LOOKUP, '0, 8'd7, '0);
		send_item(REQ_LOOKUP, '1, '0, '0);
		send_item(REQ_LOOKUP, 32'h5a5a_5a5a, '0, '0);
		send_item(REQ_TICK, '0, '0, '0);
		send_item(REQ_UNKNOWN, '0, '0, '0);

		// A zero max_age clears the whole table on the next tick.
		write_max_age(8'd0);
		send_item(REQ_TICK, '0, '0, '0);
		send_item(REQ_TICK, '0, '0, '0);

		// With max_age 1 only the refreshed entry survives and moves down to slot 0.
		write_max_age(8'd1);
		send_item(REQ_UPDATE, 32'h0000_00a1, 8'h10, 64'h1111);
		send_item(REQ_UPDATE, 32'h0000_00b2, 8'h20, 64'h2222);
		send_item(REQ_TICK, '0, '0, '0);
		send_item(REQ_UPDATE, 32'h0000_00b2, 8'h20, 64'h3333);
		send_item(REQ_TICK, '0, '0, '0);
		send_item(REQ_LOOKUP, 32'h0000_00b2, '0, '0);
		send_item(REQ_LOOKUP, 32'h0000_00a1, '0, '0);

		// Random phases: fill and overflow, wipe, fast aging, random settings, then calm.
		run_phase(300, 8'd255, 48, 2, 30);
		run_phase(100, 8'd0, 16, 10, 30);
		run_phase(200, 8'd1, 12, 20, 0);
		repeat (3)
			run_phase(170, AGE_W'($urandom_range(2, 40)), $urandom_range(4, 48),
				$urandom_range(3, 15), 20);
		run_phase(200, MAX_AGE_RST, 40, 4, 0);
		run_phase(200, 8'd3, 24, 12, 0);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Summary: %0d requests over %0d max_age settings, %0d result mismatches.",
			sent_count, age_writes + 1, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
hdl/kat_pkg.sv
hdl/kat_req_if.sv
hdl/kat_rsp_if.sv
hdl/kat_ctrl.sv
hdl/kat_datapath.sv
hdl/keyed_aging_table_unit.sv
dv/kat_table_check.sv
dv/tb.sv
